FILE: rtl/irpdt_pkg.sv
package irpdt_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HMARK  = 3'd1,
        PH_HSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4,
        PH_TRAIL  = 3'd5
    } t_phase;

    localparam int DUR_W  = 20;
    localparam int HALF_W = 16;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 3'd5;

    localparam logic [DUR_W-1:0]  RST_HEADER_MARK  = 20'd102350;
    localparam logic [DUR_W-1:0]  RST_HEADER_SPACE = 20'd50600;
    localparam logic [DUR_W-1:0]  RST_BIT_MARK     = 20'd5410;
    localparam logic [DUR_W-1:0]  RST_ZERO_SPACE   = 20'd5160;
    localparam logic [DUR_W-1:0]  RST_ONE_SPACE    = 20'd17780;
    localparam logic [HALF_W-1:0] RST_CARRIER_HALF = 16'd132;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] frame_word;
    } t_in_item;

    typedef struct packed {
        logic ir_out;
        logic mark_active;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } t_out_item;

    function automatic logic is_mark(input t_phase ph);
        return (ph == PH_HMARK) || (ph == PH_BMARK) || (ph == PH_TRAIL);
    endfunction

endpackage

FILE: rtl/ir_pulse_distance_transmitter_top.sv
// An accepted request's result is written into the output register in the following cycle.
// Throughput: one request per cycle unless the output stalls; the frame state and result register update together.
// A request is taken whenever the output register is empty or is being drained.
// Reset (synchronous, active low) sets all durations to their defaults, the frame
// state to idle and empties the output register.
module ir_pulse_distance_transmitter_top #(
    parameter int FRAME_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  irpdt_pkg::t_in_item             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output irpdt_pkg::t_out_item            o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irpdt_pkg::DUR_W-1:0]     i_cfg_data
);

    localparam int BL_W = $clog2(FRAME_BITS + 1);

    logic [irpdt_pkg::DUR_W-1:0]  r_hdr_mark, r_hdr_space, r_bit_mark, r_zero_space, r_one_space;
    logic [irpdt_pkg::HALF_W-1:0] r_half;

    irpdt_pkg::t_phase            r_phase, n_phase;
    logic [irpdt_pkg::DUR_W-1:0]  r_dur, n_dur;
    logic [FRAME_BITS-1:0]        r_shift, n_shift;
    logic [BL_W-1:0]              r_bits, n_bits;
    logic [irpdt_pkg::HALF_W-1:0] r_cc, n_cc;
    logic                         r_lvl, n_lvl;
    logic                         n_done, n_rej;

    logic                         r_out_valid;
    irpdt_pkg::t_out_item         r_out, n_out;

    logic                         accept;
    logic                         busy;
    logic [irpdt_pkg::DUR_W-1:0]  len;
    logic [irpdt_pkg::HALF_W-1:0] half_len;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign busy        = (r_phase != irpdt_pkg::PH_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign half_len = (r_half == '0) ? irpdt_pkg::HALF_W'(1) : r_half;

    always_comb begin
        case (r_phase)
            irpdt_pkg::PH_HMARK:  len = r_hdr_mark;
            irpdt_pkg::PH_HSPACE: len = r_hdr_space;
            irpdt_pkg::PH_BSPACE: len = r_shift[FRAME_BITS-1] ? r_one_space : r_zero_space;
            default:              len = r_bit_mark;
        endcase
        if (len == '0) begin
            len = irpdt_pkg::DUR_W'(1);
        end
    end

    // next frame state
    always_comb begin
        n_phase = r_phase;
        n_dur   = r_dur;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_cc    = r_cc;
        n_lvl   = r_lvl;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        if (accept) begin
            if (i_in_data.kind) begin
                if (busy) begin
                    n_rej = 1'b1;
                end else begin
                    n_shift = FRAME_BITS'(i_in_data.frame_word);
                    n_bits  = BL_W'(FRAME_BITS);
                    n_phase = irpdt_pkg::PH_HMARK;
                end
            end else if (busy) begin
                if (irpdt_pkg::is_mark(r_phase)) begin
                    n_cc = r_cc + 1'b1;
                    if (n_cc >= half_len) begin
                        n_cc  = '0;
                        n_lvl = ~r_lvl;
                    end
                end
                n_dur = r_dur + 1'b1;
                if (n_dur >= len) begin
                    case (r_phase)
                        irpdt_pkg::PH_HMARK: begin
                            n_phase = irpdt_pkg::PH_HSPACE;
                        end
                        irpdt_pkg::PH_HSPACE: begin
                            n_phase = (r_bits != '0) ? irpdt_pkg::PH_BMARK : irpdt_pkg::PH_TRAIL;
                        end
                        irpdt_pkg::PH_BMARK: begin
                            n_phase = irpdt_pkg::PH_BSPACE;
                        end
                        irpdt_pkg::PH_BSPACE: begin
                            if (r_bits != '0) begin
                                n_bits = r_bits - 1'b1;
                            end
                            n_shift = r_shift << 1;
                            n_phase = (n_bits != '0) ? irpdt_pkg::PH_BMARK : irpdt_pkg::PH_TRAIL;
                        end
                        default: begin
                            n_phase = irpdt_pkg::PH_IDLE;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
            if (n_phase != r_phase) begin
                n_dur = '0;
                n_cc  = '0;
                n_lvl = irpdt_pkg::is_mark(n_phase);
            end
        end
    end

    // result of this request
    always_comb begin
        n_out.mark_active    = irpdt_pkg::is_mark(n_phase);
        n_out.ir_out         = n_out.mark_active && n_lvl;
        n_out.busy_res       = (n_phase != irpdt_pkg::PH_IDLE);
        n_out.frame_done     = n_done;
        n_out.start_rejected = n_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= irpdt_pkg::RST_HEADER_MARK;
            r_hdr_space  <= irpdt_pkg::RST_HEADER_SPACE;
            r_bit_mark   <= irpdt_pkg::RST_BIT_MARK;
            r_zero_space <= irpdt_pkg::RST_ZERO_SPACE;
            r_one_space  <= irpdt_pkg::RST_ONE_SPACE;
            r_half       <= irpdt_pkg::RST_CARRIER_HALF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                irpdt_pkg::CFG_HEADER_MARK:  r_hdr_mark   <= i_cfg_data;
                irpdt_pkg::CFG_HEADER_SPACE: r_hdr_space  <= i_cfg_data;
                irpdt_pkg::CFG_BIT_MARK:     r_bit_mark   <= i_cfg_data;
                irpdt_pkg::CFG_ZERO_SPACE:   r_zero_space <= i_cfg_data;
                irpdt_pkg::CFG_ONE_SPACE:    r_one_space  <= i_cfg_data;
                irpdt_pkg::CFG_CARRIER_HALF: r_half       <= i_cfg_data[irpdt_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= irpdt_pkg::PH_IDLE;
            r_dur       <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_cc        <= '0;
            r_lvl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_dur   <= n_dur;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_cc    <= n_cc;
            r_lvl   <= n_lvl;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule
